// ===== rtl/core/hpt_pkg.sv =====
// hpt_pkg: types, constants and tables shared by the homogeneous 2d point transform
// used by hpt_front, hpt_queue, hpt_back and homogeneous_2d_point_transform
`default_nettype none

package hpt_pkg;

  localparam int FracBits        = 16;
  localparam int AngFrac         = 24;
  localparam int GuardBits       = 8;
  localparam int GainFrac        = 30;
  localparam int CordicStagesDef = 16;
  localparam int QueueDepthDef   = 4;
  localparam int ZW              = 35;
  localparam int CW              = 50;

  localparam logic signed [ZW-1:0] AngFull    = 35'sd6039797760;
  localparam logic signed [ZW-1:0] AngHalf    = 35'sd3019898880;
  localparam logic signed [ZW-1:0] AngQuarter = 35'sd1509949440;

  typedef enum logic [1:0] {
    ModeMove   = 2'd0,
    ModeScale  = 2'd1,
    ModeMirror = 2'd2,
    ModeRotate = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CfgMode   = 3'd0,
    CfgParamX = 3'd1,
    CfgParamY = 3'd2,
    CfgMirror = 3'd3,
    CfgAngle  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_w;
  } hpt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_w;
    logic               overflow;
  } hpt_out_t;

  typedef struct packed {
    mode_e                op;
    logic signed [32:0]   mx;
    logic signed [32:0]   my;
    logic signed [31:0]   ax;
    logic signed [31:0]   bx;
    logic signed [31:0]   ay;
    logic signed [31:0]   by;
    logic signed [31:0]   w;
    logic signed [ZW-1:0] z;
    logic                 fold;
  } hpt_item_t;

  typedef struct packed {
    mode_e                op;
    logic signed [32:0]   mx;
    logic signed [32:0]   my;
    logic signed [63:0]   px;
    logic signed [63:0]   py;
    logic signed [31:0]   w;
    logic signed [ZW-1:0] z;
    logic                 fold;
  } hpt_mul_t;

  typedef struct packed {
    mode_e                op;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic signed [31:0]   w;
  } hpt_stg_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 35'sd754974720;
      5'd1:    v = 35'sd445687602;
      5'd2:    v = 35'sd235489088;
      5'd3:    v = 35'sd119537938;
      5'd4:    v = 35'sd60000934;
      5'd5:    v = 35'sd30029717;
      5'd6:    v = 35'sd15018523;
      5'd7:    v = 35'sd7509720;
      5'd8:    v = 35'sd3754917;
      5'd9:    v = 35'sd1877466;
      5'd10:   v = 35'sd938734;
      5'd11:   v = 35'sd469367;
      5'd12:   v = 35'sd234684;
      5'd13:   v = 35'sd117342;
      5'd14:   v = 35'sd58671;
      5'd15:   v = 35'sd29335;
      5'd16:   v = 35'sd14668;
      5'd17:   v = 35'sd7334;
      5'd18:   v = 35'sd3667;
      5'd19:   v = 35'sd1833;
      5'd20:   v = 35'sd917;
      5'd21:   v = 35'sd458;
      5'd22:   v = 35'sd229;
      5'd23:   v = 35'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] cordic_gain(input int n);
    logic signed [31:0] k;
    case (n)
      8:       k = 32'sd652039507;
      9:       k = 32'sd652034532;
      10:      k = 32'sd652033289;
      11:      k = 32'sd652032978;
      12:      k = 32'sd652032900;
      13:      k = 32'sd652032881;
      14:      k = 32'sd652032876;
      default: k = 32'sd652032874;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hpt_front.sv =====
// hpt_front: configuration registers, input beat capture and per-mode operand selection
// depends on hpt_pkg
`default_nettype none

module hpt_front #(
  parameter int NSTG = hpt_pkg::CordicStagesDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [2:0]          cfg_index_i,
  input  wire  [31:0]         cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  hpt_pkg::hpt_in_t    in_data_i,
  output logic                item_valid_o,
  input  wire                 item_ready_i,
  output hpt_pkg::hpt_item_t  item_o
);
  import hpt_pkg::*;

  mode_e              mode_q;
  logic signed [31:0] px_q, py_q;
  logic               mir_q;
  logic signed [25:0] ang_q;

  logic                 vld_q;
  hpt_item_t            item_q, item_d;
  logic signed [ZW-1:0] za, zr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeMove;
      px_q   <= '0;
      py_q   <= '0;
      mir_q  <= 1'b0;
      ang_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMode:   mode_q <= mode_e'(cfg_data_i[1:0]);
        CfgParamX: px_q   <= $signed(cfg_data_i);
        CfgParamY: py_q   <= $signed(cfg_data_i);
        CfgMirror: mir_q  <= cfg_data_i[0];
        CfgAngle:  ang_q  <= $signed(cfg_data_i[25:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    za = ZW'(ang_q) <<< (AngFrac - FracBits);
    if (za >= AngHalf) begin
      zr = za - AngFull;
    end else if (za < -AngHalf) begin
      zr = za + AngFull;
    end else begin
      zr = za;
    end
    item_d      = '0;
    item_d.op   = mode_q;
    item_d.w    = in_data_i.in_w;
    item_d.mx   = 33'(in_data_i.in_x);
    item_d.my   = 33'(in_data_i.in_y);
    item_d.z    = zr;
    if (zr > AngQuarter) begin
      item_d.z    = zr - AngHalf;
      item_d.fold = 1'b1;
    end else if (zr < -AngQuarter) begin
      item_d.z    = zr + AngHalf;
      item_d.fold = 1'b1;
    end
    case (mode_q)
      ModeMove: begin
        item_d.ax = in_data_i.in_w;
        item_d.bx = px_q;
        item_d.ay = in_data_i.in_w;
        item_d.by = py_q;
      end
      ModeScale: begin
        item_d.ax = in_data_i.in_x;
        item_d.bx = px_q;
        item_d.ay = in_data_i.in_y;
        item_d.by = py_q;
      end
      ModeMirror: begin
        if (mir_q) begin
          item_d.mx = -33'(in_data_i.in_x);
        end else begin
          item_d.my = -33'(in_data_i.in_y);
        end
      end
      ModeRotate: begin
        item_d.ax = in_data_i.in_x;
        item_d.bx = cordic_gain(NSTG);
        item_d.ay = in_data_i.in_y;
        item_d.by = cordic_gain(NSTG);
      end
      default: ;
    endcase
  end

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (item_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hpt_queue.sv =====
// hpt_queue: short item queue between front and back
// depends on hpt_pkg
`default_nettype none

module hpt_queue #(
  parameter int DEPTH = hpt_pkg::QueueDepthDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  output logic                push_ready_o,
  input  hpt_pkg::hpt_item_t  push_data_i,
  output logic                pop_valid_o,
  input  wire                 pop_ready_i,
  output hpt_pkg::hpt_item_t  pop_data_o
);
  import hpt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  hpt_item_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != NW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hpt_back.sv =====
// hpt_back: multiply stage, cordic stage pipeline, rounding, saturation and output register
// depends on hpt_pkg
`default_nettype none

module hpt_back #(
  parameter int NSTG = hpt_pkg::CordicStagesDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  output logic                item_ready_o,
  input  hpt_pkg::hpt_item_t  item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output hpt_pkg::hpt_out_t   out_data_o
);
  import hpt_pkg::*;

  logic             en;
  hpt_mul_t         mul_q, mul_d;
  logic             mvld_q;
  hpt_stg_t         stg_q [NSTG+1];
  hpt_stg_t         stg0;
  logic [NSTG:0]    svld_q;
  hpt_out_t         out_q, out_d;
  logic             ovld_q;

  logic signed [63:0]   rx16, ry16, rx22, ry22;
  logic signed [CW-1:0] fx, fy;
  logic [32:0]          sx, sy;

  function automatic hpt_stg_t cordic_step(input hpt_stg_t s, input int k);
    hpt_stg_t n;
    n = s;
    if (s.op == ModeRotate) begin
      if (!s.z[ZW-1]) begin
        n.cx = s.cx - (s.cy >>> k);
        n.cy = s.cy + (s.cx >>> k);
        n.z  = s.z - atan_deg(5'(k));
      end else begin
        n.cx = s.cx + (s.cy >>> k);
        n.cy = s.cy - (s.cx >>> k);
        n.z  = s.z + atan_deg(5'(k));
      end
    end
    return n;
  endfunction

  function automatic logic [32:0] sat32(input logic signed [CW-1:0] v);
    logic [32:0] r;
    if (v > CW'(64'sd2147483647)) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < CW'(-64'sd2147483648)) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  assign en           = !ovld_q || out_ready_i;
  assign item_ready_o = en;

  always_comb begin
    mul_d      = '0;
    mul_d.op   = item_i.op;
    mul_d.mx   = item_i.mx;
    mul_d.my   = item_i.my;
    mul_d.w    = item_i.w;
    mul_d.z    = item_i.z;
    mul_d.fold = item_i.fold;
    mul_d.px   = 64'(item_i.ax) * 64'(item_i.bx);
    mul_d.py   = 64'(item_i.ay) * 64'(item_i.by);
  end

  always_comb begin
    rx16 = (mul_q.px + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    ry16 = (mul_q.py + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    rx22 = (mul_q.px + (64'sd1 <<< (GainFrac - GuardBits - 1))) >>> (GainFrac - GuardBits);
    ry22 = (mul_q.py + (64'sd1 <<< (GainFrac - GuardBits - 1))) >>> (GainFrac - GuardBits);
    stg0    = '0;
    stg0.op = mul_q.op;
    stg0.z  = mul_q.z;
    stg0.w  = mul_q.w;
    case (mul_q.op)
      ModeMove: begin
        stg0.cx = CW'(mul_q.mx) + CW'(rx16);
        stg0.cy = CW'(mul_q.my) + CW'(ry16);
      end
      ModeScale: begin
        stg0.cx = CW'(rx16);
        stg0.cy = CW'(ry16);
      end
      ModeMirror: begin
        stg0.cx = CW'(mul_q.mx);
        stg0.cy = CW'(mul_q.my);
      end
      ModeRotate: begin
        stg0.cx = mul_q.fold ? -CW'(rx22) : CW'(rx22);
        stg0.cy = mul_q.fold ? -CW'(ry22) : CW'(ry22);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (stg_q[NSTG].op == ModeRotate) begin
      fx = (stg_q[NSTG].cx + CW'(1 << (GuardBits - 1))) >>> GuardBits;
      fy = (stg_q[NSTG].cy + CW'(1 << (GuardBits - 1))) >>> GuardBits;
    end else begin
      fx = stg_q[NSTG].cx;
      fy = stg_q[NSTG].cy;
    end
    sx             = sat32(fx);
    sy             = sat32(fy);
    out_d.out_x    = sx[31:0];
    out_d.out_y    = sy[31:0];
    out_d.out_w    = stg_q[NSTG].w;
    out_d.overflow = sx[32] | sy[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
      svld_q <= '0;
      ovld_q <= 1'b0;
    end else if (en) begin
      mvld_q <= item_valid_i;
      svld_q <= {svld_q[NSTG-1:0], mvld_q};
      ovld_q <= svld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q    <= mul_d;
      stg_q[0] <= stg0;
      for (int k = 0; k < NSTG; k++) begin
        stg_q[k+1] <= cordic_step(stg_q[k], k);
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/homogeneous_2d_point_transform.sv =====
// homogeneous_2d_point_transform: top level, front, queue and back part
// path: front register, queue, multiply stage, cordic stages, output register
// throughput: one beat per cycle (pipelined cordic) while out_ready_i is high
// reset: asynchronous active low; config to zero, queue and pipeline emptied
// depends on hpt_pkg, hpt_front, hpt_queue, hpt_back
`default_nettype none

module homogeneous_2d_point_transform #(
  parameter int CORDIC_STAGES = hpt_pkg::CordicStagesDef,
  parameter int QUEUE_DEPTH   = hpt_pkg::QueueDepthDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [2:0]         cfg_index_i,
  input  wire  [31:0]        cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  hpt_pkg::hpt_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output hpt_pkg::hpt_out_t  out_data_o
);
  import hpt_pkg::*;

  localparam int NStg = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);

  logic      f_valid, f_ready, q_valid, q_ready;
  hpt_item_t f_item, q_item;

  hpt_front #(.NSTG(NStg)) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  hpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_item)
  );

  hpt_back #(.NSTG(NStg)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_ready_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> f_valid && !f_ready)
    else $error("input stalled with no item waiting in front");

  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.out_x == 32'sh7fff_ffff || out_data_o.out_x == 32'sh8000_0000 ||
      out_data_o.out_y == 32'sh7fff_ffff || out_data_o.out_y == 32'sh8000_0000)
    else $error("overflow flagged without a saturated coordinate");

endmodule

`default_nettype wire
